@@ rtl/ssh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Space-saving heavy hitters package
// Shared sizes, codes, structs and helpers for the flow monitor.
// ----------------------------------------------------------------------------
package ssh_pkg;

    localparam int CAPACITY   = 32;
    localparam int COUNT_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int ADDR_W     = 32;

    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [IDX_W-1:0]      idx_t;

    localparam cnt_t COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ACT_UPDATE = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_REPORT = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        cnt_t              cnt;
        cnt_t              err;
    } entry_t;

    typedef struct packed {
        logic   en;
        idx_t   idx;
        entry_t data;
    } wr_t;

    // Search token passed along the row of cells.
    typedef struct packed {
        logic active;
        logic hit;
        idx_t hit_idx;
        cnt_t hit_cnt;
        cnt_t hit_err;
        logic free;
        idx_t free_idx;
        logic min_set;
        cnt_t min_cnt;
        idx_t min_idx;
    } carry_t;

    function automatic cnt_t bump(input cnt_t c);
        bump = (c == COUNT_MAX) ? COUNT_MAX : c + cnt_t'(1);
    endfunction

endpackage

@@ rtl/ssh_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monitor cell
// Holds one table entry and advances the search token by one place a cycle.
// ----------------------------------------------------------------------------
module ssh_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ssh_pkg::idx_t             cell_idx,
    input  logic [ssh_pkg::ADDR_W-1:0] key_src,
    input  logic [ssh_pkg::ADDR_W-1:0] key_dst,
    input  ssh_pkg::carry_t           carry_in,
    output ssh_pkg::carry_t           carry_out,
    input  ssh_pkg::wr_t              wr,
    output ssh_pkg::entry_t           entry
);

    ssh_pkg::entry_t entry_reg;
    ssh_pkg::carry_t carry_reg;
    ssh_pkg::carry_t carry_next;
    logic            occupied;

    assign occupied = (entry_reg.cnt != '0);

    always_comb
    begin
        carry_next = carry_in;
        if (carry_in.active)
        begin
            if (!carry_in.hit && occupied && entry_reg.src == key_src
                && entry_reg.dst == key_dst)
            begin
                carry_next.hit     = 1'b1;
                carry_next.hit_idx = cell_idx;
                carry_next.hit_cnt = entry_reg.cnt;
                carry_next.hit_err = entry_reg.err;
            end
            if (!carry_in.free && !occupied)
            begin
                carry_next.free     = 1'b1;
                carry_next.free_idx = cell_idx;
            end
            // Strict compare keeps the lowest index on ties.
            if (!carry_in.min_set || entry_reg.cnt < carry_in.min_cnt)
            begin
                carry_next.min_set = 1'b1;
                carry_next.min_cnt = entry_reg.cnt;
                carry_next.min_idx = cell_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
            entry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
            if (wr.en && wr.idx == cell_idx)
            begin
                entry_reg <= wr.data;
            end
        end
    end

    assign carry_out = carry_reg;
    assign entry     = entry_reg;

endmodule

@@ rtl/space_saving_heavy_hitters.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Space-saving heavy hitters
// Top-k flow monitor over a row of cells, one table entry per cell.
// ----------------------------------------------------------------------------
// An update or query result is offered once the search token has walked
// the row of CAPACITY cells and the result has been registered.
// One request at a time: the slave side is ready only in the idle state.
// A report scans one entry per cycle, but may pause while the output stalls.
// Reset clears every entry at once (count zero marks an empty entry) and
// sets the threshold to one; there is no clearing pass.
// ----------------------------------------------------------------------------
module space_saving_heavy_hitters (
    input  logic          clk,
    input  logic          rst_n,
    // Slave side: tdata = src_address, dst_address from bit 0 up;
    // tuser = action.
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    // Master side: tdata = key_src_out, key_dst_out, upper_estimate,
    // lower_estimate from bit 0 up; tuser = entry_found, replaced_other,
    // report_valid from bit 0 up; tlast = last.
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,
    output logic [2:0]    m_tuser,
    output logic          m_tlast,
    // Threshold register.
    input  logic          heavy_threshold_we,
    input  logic [31:0]   heavy_threshold_wdata
);

    localparam int CAP = ssh_pkg::CAPACITY;

    ssh_pkg::state_t state_reg, state_next;
    logic [31:0]     thr_reg;
    logic [ssh_pkg::ADDR_W-1:0] key_src_reg, key_dst_reg;
    logic            query_reg, query_next;
    logic            start_reg, start_next;
    ssh_pkg::carry_t res_reg, res_next;

    // Report scan.
    ssh_pkg::idx_t   ptr_reg, ptr_next;
    logic            scan_end_reg, scan_end_next;
    logic            pend_valid_reg, pend_valid_next;
    ssh_pkg::entry_t pend_reg, pend_next;

    // Output register.
    logic            out_valid_reg;
    logic [127:0]    out_data_reg;
    logic [2:0]      out_user_reg;
    logic            out_last_reg;

    ssh_pkg::carry_t chain_head;
    ssh_pkg::carry_t chain [0:CAP];
    ssh_pkg::entry_t entries [0:CAP-1];
    ssh_pkg::wr_t    wr;

    logic            accept;
    logic            out_free;
    logic            push;
    ssh_pkg::entry_t push_entry;
    logic            push_found, push_repl, push_rv, push_last;
    ssh_pkg::entry_t cur;
    logic            cur_heavy;
    ssh_pkg::cnt_t   new_cnt, new_err;
    ssh_pkg::idx_t   tgt_idx;
    logic            repl;

    assign s_tready = (state_reg == ssh_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // The token enters the first cell for one cycle after an accepted update or query.
    always_comb
    begin
        chain_head        = '0;
        chain_head.active = start_reg;
    end

    assign chain[0] = chain_head;

    for (genvar g = 0; g < CAP; g++)
    begin : g_cells
        ssh_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (ssh_pkg::idx_t'(g)),
            .key_src   (key_src_reg),
            .key_dst   (key_dst_reg),
            .carry_in  (chain[g]),
            .carry_out (chain[g+1]),
            .wr        (wr),
            .entry     (entries[g])
        );
    end

    assign cur       = entries[ptr_reg];
    assign cur_heavy = (cur.cnt != '0) && (32'(cur.cnt) >= thr_reg);

    // Target of an update, resolved once the token has left the last cell.
    always_comb
    begin
        repl = 1'b0;
        if (res_reg.hit)
        begin
            tgt_idx = res_reg.hit_idx;
            new_cnt = ssh_pkg::bump(res_reg.hit_cnt);
            new_err = res_reg.hit_err;
        end
        else if (res_reg.free)
        begin
            tgt_idx = res_reg.free_idx;
            new_cnt = ssh_pkg::cnt_t'(1);
            new_err = '0;
        end
        else
        begin
            tgt_idx = res_reg.min_idx;
            new_cnt = ssh_pkg::bump(res_reg.min_cnt);
            new_err = res_reg.min_cnt;
            repl    = 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        query_next      = query_reg;
        start_next      = 1'b0;
        res_next        = res_reg;
        ptr_next        = ptr_reg;
        scan_end_next   = scan_end_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        wr              = '0;
        push            = 1'b0;
        push_entry      = '0;
        push_found      = 1'b0;
        push_repl       = 1'b0;
        push_rv         = 1'b0;
        push_last       = 1'b0;

        case (state_reg)
            ssh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (ssh_pkg::action_t'(s_tuser))
                        ssh_pkg::ACT_UPDATE,
                        ssh_pkg::ACT_QUERY:
                        begin
                            query_next = (ssh_pkg::action_t'(s_tuser)
                                          == ssh_pkg::ACT_QUERY);
                            start_next = 1'b1;
                            state_next = ssh_pkg::ST_SWEEP;
                        end
                        ssh_pkg::ACT_REPORT:
                        begin
                            ptr_next        = '0;
                            scan_end_next   = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = ssh_pkg::ST_REPORT;
                        end
                        default:
                        begin
                            state_next = ssh_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ssh_pkg::ST_SWEEP:
            begin
                if (chain[CAP].active)
                begin
                    res_next   = chain[CAP];
                    state_next = ssh_pkg::ST_DONE;
                end
            end
            ssh_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    push           = 1'b1;
                    push_last      = 1'b1;
                    push_entry.src = key_src_reg;
                    push_entry.dst = key_dst_reg;
                    push_found     = res_reg.hit;
                    if (query_reg)
                    begin
                        if (res_reg.hit)
                        begin
                            push_entry.cnt = res_reg.hit_cnt;
                            push_entry.err = res_reg.hit_err;
                        end
                    end
                    else
                    begin
                        push_repl      = repl;
                        push_entry.cnt = new_cnt;
                        push_entry.err = new_err;
                        wr.en          = 1'b1;
                        wr.idx         = tgt_idx;
                        wr.data.src    = key_src_reg;
                        wr.data.dst    = key_dst_reg;
                        wr.data.cnt    = new_cnt;
                        wr.data.err    = new_err;
                    end
                    state_next = ssh_pkg::ST_IDLE;
                end
            end
            ssh_pkg::ST_REPORT:
            begin
                if (!scan_end_reg)
                begin
                    // A heavy entry is held back until the next one is found, so that the last
                    // one can be marked.
                    if (!(cur_heavy && pend_valid_reg && !out_free))
                    begin
                        if (cur_heavy)
                        begin
                            if (pend_valid_reg)
                            begin
                                push       = 1'b1;
                                push_entry = pend_reg;
                                push_found = 1'b1;
                                push_rv    = 1'b1;
                            end
                            pend_valid_next = 1'b1;
                            pend_next       = cur;
                        end
                        if (ptr_reg == ssh_pkg::idx_t'(CAP - 1))
                        begin
                            scan_end_next = 1'b1;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + ssh_pkg::idx_t'(1);
                        end
                    end
                end
                else if (out_free)
                begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    if (pend_valid_reg)
                    begin
                        push_entry = pend_reg;
                        push_found = 1'b1;
                        push_rv    = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ssh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ssh_pkg::ST_IDLE;
            thr_reg        <= 32'd1;
            start_reg      <= 1'b0;
            query_reg      <= 1'b0;
            ptr_reg        <= '0;
            scan_end_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            start_reg      <= start_next;
            query_reg      <= query_next;
            ptr_reg        <= ptr_next;
            scan_end_reg   <= scan_end_next;
            pend_valid_reg <= pend_valid_next;
            res_reg        <= res_next;
            if (heavy_threshold_we)
            begin
                thr_reg <= heavy_threshold_wdata;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (accept)
        begin
            key_src_reg <= s_tdata[31:0];
            key_dst_reg <= s_tdata[63:32];
        end
        if (push)
        begin
            out_data_reg <= {32'(push_entry.cnt - push_entry.err),
                             32'(push_entry.cnt), push_entry.dst, push_entry.src};
            out_user_reg <= {push_rv, push_repl, push_found};
            out_last_reg <= push_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // The token leaves the row only while a lookup is waiting for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        chain[CAP].active |-> state_reg == ssh_pkg::ST_SWEEP)
        else $error("search token left the row outside a lookup");

    // An eviction never comes with a hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_user_reg[1] |-> !out_user_reg[0])
        else $error("eviction flagged on a monitored flow");

    // A reported entry is heavy.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_user_reg[2] |-> out_data_reg[95:64] >= thr_reg)
        else $error("reported entry below threshold");

endmodule
